/* rtl/itf_pkg.sv */
// Shared constants, types and the digit character function of the integer to text formatter.
`default_nettype none

package itf_pkg;

    // Number and digit sizes.
    localparam int VALUE_BITS = 32;
    localparam int MAX_DIGITS = 32;
    localparam int DIGIT_W    = 6;
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    // The shared divider retires this many quotient bits per cycle.
    localparam int STEP_BITS = 4;
    localparam int DIV_STEPS = VALUE_BITS / STEP_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Formatting field widths.
    localparam int RADIX_W   = 6;
    localparam int WIDTH_W   = 7;
    localparam int PREC_W    = 6;
    localparam int POS_W     = 7;
    localparam int IDX_W     = 6;
    localparam int OUT_LIMIT = 64;

    // Stream widths.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 8;

    // Bit offsets of the input fields inside s_axis_tdata.
    localparam int OFF_VALUE  = 0;
    localparam int OFF_RADIX  = 32;
    localparam int OFF_WIDTH  = 38;
    localparam int OFF_MIND   = 45;
    localparam int OFF_SIGNED = 51;
    localparam int OFF_PLUS   = 52;
    localparam int OFF_SPACE  = 53;
    localparam int OFF_LEFT   = 54;
    localparam int OFF_ZPAD   = 55;
    localparam int OFF_ALT    = 56;
    localparam int OFF_UPPER  = 57;

    // Radix limits and the radices that take a prefix.
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

    // ASCII codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic size;
        logic bound;
        logic emit;
        logic err;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic radix_bad;
        logic div_done;
        logic out_free;
        logic emit_last;
    } t_sts;

    // Digit value 0 to 35 to its ASCII character, letters in either case.
    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_A_UP : CH_A_LO;
        if (d < DIGIT_W'(10)) begin
            digit_char = CH_ZERO + {2'b00, d};
        end else begin
            digit_char = base + {2'b00, d} - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/integer_to_text_formatter.sv */
// Top level of the integer to text formatter.
//
// One input transaction on the s_axis channel carries a 32-bit number with its
// radix (2 to 36), field width, minimum digit count and printf style flags. The
// block answers with the formatted text on the m_axis channel, one ASCII
// character per transaction, m_axis_tlast high on the final character.
// A radix outside 2 to 36 gives one transaction with character 0 and
// m_axis_tuser (error) high, tlast high.
// Per number: the accept, then the digits one at a time from the shared
// divider (4 quotient bits per cycle over 32 bits), a sizing step and a
// layout step, then one character per cycle while the receiver takes them.
// An error goes from the accept straight to its one character.
// The divider sets the rate; one number is handled at a time, and
// s_axis_tready is high only between numbers. The last character may still sit
// in the output register while the next number is taken.
// When the receiver stalls, the output register holds its character and the
// emission waits. Reset (i_rst_n low at a clock edge) clears the controller and
// the output valid; the block is ready on the first cycle after reset.
`default_nettype none

module integer_to_text_formatter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // value[31:0], radix[37:32], fmt_width[44:38], min_digits[50:45], is_signed[51],
    // show_plus[52], space_sign[53], left_justify[54], zero_pad[55], alt_prefix[56],
    // upper_case[57], zeros above
    input  wire logic [itf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // character[7:0]
    output logic [itf_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast,
    // error[0]
    output logic                               m_axis_tuser
);

    itf_pkg::t_cmd cmd;
    itf_pkg::t_sts sts;

    itf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    itf_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_err   (m_axis_tuser)
    );

endmodule

`default_nettype wire

/* rtl/itf_ctrl.sv */
// Controller state machine of the integer to text formatter.
`default_nettype none

module itf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output itf_pkg::t_cmd      o_cmd,
    input  wire itf_pkg::t_sts i_sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_SIZE  = 3'd2;
    localparam logic [2:0] ST_BOUND = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_ERR   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.radix_bad ? ST_ERR : ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_SIZE;
                end
            end
            ST_SIZE: begin
                o_cmd.size = 1'b1;
                n_state    = ST_BOUND;
            end
            ST_BOUND: begin
                o_cmd.bound = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.err = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A new number is taken only between numbers.
    assign o_in_ready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

/* rtl/itf_dpath.sv */
// Datapath of the integer to text formatter: divider, digit register file, layout and output register.
`default_nettype none

module itf_dpath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire itf_pkg::t_cmd                   i_cmd,
    output itf_pkg::t_sts                        o_sts,
    input  wire logic [itf_pkg::S_TDATA_W-1:0]   i_item,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic [itf_pkg::M_TDATA_W-1:0]        o_out_char,
    output logic                                 o_out_last,
    output logic                                 o_out_err
);

    // Input field decode.
    logic [itf_pkg::VALUE_BITS-1:0] in_value;
    logic [itf_pkg::RADIX_W-1:0]    in_radix;
    logic [itf_pkg::WIDTH_W-1:0]    in_width;
    logic [itf_pkg::PREC_W-1:0]     in_min_digits;
    logic                           in_is_signed;
    logic                           in_show_plus;
    logic                           in_space_sign;
    logic                           in_left;
    logic                           in_zero_pad;
    logic                           in_alt;
    logic                           in_upper;
    logic                           in_neg;
    logic [itf_pkg::VALUE_BITS-1:0] in_mag;
    logic [7:0]                     in_sign_char;
    logic                           in_sign_len;
    logic [1:0]                     in_pfx_len;

    assign in_value      = i_item[itf_pkg::OFF_VALUE +: itf_pkg::VALUE_BITS];
    assign in_radix      = i_item[itf_pkg::OFF_RADIX +: itf_pkg::RADIX_W];
    assign in_width      = i_item[itf_pkg::OFF_WIDTH +: itf_pkg::WIDTH_W];
    assign in_min_digits = i_item[itf_pkg::OFF_MIND +: itf_pkg::PREC_W];
    assign in_is_signed  = i_item[itf_pkg::OFF_SIGNED];
    assign in_show_plus  = i_item[itf_pkg::OFF_PLUS];
    assign in_space_sign = i_item[itf_pkg::OFF_SPACE];
    assign in_left       = i_item[itf_pkg::OFF_LEFT];
    assign in_zero_pad   = i_item[itf_pkg::OFF_ZPAD];
    assign in_alt        = i_item[itf_pkg::OFF_ALT];
    assign in_upper      = i_item[itf_pkg::OFF_UPPER];

    // Magnitude and sign; the most negative value negates to itself, read unsigned.
    assign in_neg = in_is_signed && in_value[itf_pkg::VALUE_BITS-1];
    assign in_mag = in_neg ? (~in_value + itf_pkg::VALUE_BITS'(1)) : in_value;

    always_comb begin
        in_sign_char = itf_pkg::CH_SPACE;
        in_sign_len  = 1'b0;
        if (in_neg) begin
            in_sign_char = itf_pkg::CH_MINUS;
            in_sign_len  = 1'b1;
        end else if (in_is_signed && in_show_plus) begin
            in_sign_char = itf_pkg::CH_PLUS;
            in_sign_len  = 1'b1;
        end else if (in_is_signed && in_space_sign) begin
            in_sign_char = itf_pkg::CH_SPACE;
            in_sign_len  = 1'b1;
        end
    end

    // With the alternate flag, the prefix is "0x" (or "0X") for hex and "0" for octal.
    always_comb begin
        in_pfx_len = 2'd0;
        if (in_alt && in_radix == itf_pkg::RADIX_HEX) begin
            in_pfx_len = 2'd2;
        end else if (in_alt && in_radix == itf_pkg::RADIX_OCT) begin
            in_pfx_len = 2'd1;
        end
    end

    // Item registers.
    logic [itf_pkg::VALUE_BITS-1:0] r_work;
    logic [itf_pkg::RADIX_W-1:0]    r_radix;
    logic [itf_pkg::WIDTH_W-1:0]    r_width;
    logic [itf_pkg::PREC_W-1:0]     r_min_digits;
    logic [7:0]                     r_sign_char;
    logic                           r_sign_len;
    logic [1:0]                     r_pfx_len;
    logic                           r_left;
    logic                           r_zpad;
    logic                           r_upper;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_radix      <= in_radix;
            r_width      <= in_width;
            r_min_digits <= in_min_digits;
            r_sign_char  <= in_sign_char;
            r_sign_len   <= in_sign_len;
            r_pfx_len    <= in_pfx_len;
            r_left       <= in_left;
            r_zpad       <= in_zero_pad && !in_left;
            r_upper      <= in_upper;
        end
    end

    // Divider: restoring division, a group of quotient bits per cycle, MSB first.
    // The partial remainder always stays below the radix, so it fits a digit.
    logic [itf_pkg::DIGIT_W-1:0]    r_part;
    logic [itf_pkg::STEP_W-1:0]     r_step;
    logic [itf_pkg::CNT_W-1:0]      r_cnt;
    logic [itf_pkg::DIGIT_W:0]      div_trial;
    logic [itf_pkg::DIGIT_W-1:0]    div_rem;
    logic [itf_pkg::STEP_BITS-1:0]  div_qbits;
    logic [itf_pkg::VALUE_BITS-1:0] div_quot;
    logic                           div_last;
    logic                           div_done;

    always_comb begin
        div_rem   = r_part;
        div_qbits = '0;
        div_trial = '0;
        for (int k = itf_pkg::STEP_BITS - 1; k >= 0; k--) begin
            div_trial = {div_rem, r_work[itf_pkg::VALUE_BITS - itf_pkg::STEP_BITS + k]};
            if (div_trial >= {1'b0, r_radix}) begin
                div_trial    = div_trial - {1'b0, r_radix};
                div_qbits[k] = 1'b1;
            end
            div_rem = div_trial[itf_pkg::DIGIT_W-1:0];
        end
    end

    // The work word shifts left; quotient bits fill in from the bottom.
    assign div_quot = {r_work[itf_pkg::VALUE_BITS-itf_pkg::STEP_BITS-1:0], div_qbits};
    assign div_last = (r_step == itf_pkg::STEP_W'(itf_pkg::DIV_STEPS - 1));
    assign div_done = div_last &&
                      ((div_quot == '0) || (r_cnt == itf_pkg::CNT_W'(itf_pkg::MAX_DIGITS - 1)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work <= in_mag;
            r_part <= '0;
        end else if (i_cmd.div_step) begin
            r_work <= div_quot;
            r_part <= div_last ? '0 : div_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.load) begin
            r_step <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_step <= r_step + itf_pkg::STEP_W'(1);
            if (div_last) begin
                r_cnt <= r_cnt + itf_pkg::CNT_W'(1);
            end
        end
    end

    // Digit register file, least significant digit at entry zero.
    logic [itf_pkg::DIGIT_W-1:0] r_store [itf_pkg::MAX_DIGITS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step && div_last) begin
            r_store[r_cnt[itf_pkg::DIG_IDX_W-1:0]] <= div_rem;
        end
    end

    // Sizing: digit count raised to the precision, then the padding.
    logic [itf_pkg::PREC_W-1:0] size_prec;
    logic [itf_pkg::POS_W-1:0]  size_fixed;
    logic [itf_pkg::PREC_W-1:0] r_prec;
    logic [itf_pkg::POS_W-1:0]  r_pad;

    assign size_prec  = (itf_pkg::PREC_W'(r_cnt) > r_min_digits) ?
                        itf_pkg::PREC_W'(r_cnt) : r_min_digits;
    assign size_fixed = itf_pkg::POS_W'(r_sign_len) + itf_pkg::POS_W'(r_pfx_len) +
                        itf_pkg::POS_W'(size_prec);

    always_ff @(posedge i_clk) begin
        if (i_cmd.size) begin
            r_prec <= size_prec;
            r_pad  <= (r_width > size_fixed) ? (r_width - size_fixed) : '0;
        end
    end

    // Layout: end positions of each run of characters.
    logic [itf_pkg::POS_W-1:0] r_b1;   // leading spaces
    logic [itf_pkg::POS_W-1:0] r_b2;   // sign
    logic [itf_pkg::POS_W-1:0] r_b3;   // prefix
    logic [itf_pkg::POS_W-1:0] r_b5;   // zero padding and precision zeros
    logic [itf_pkg::POS_W-1:0] r_b6;   // digits
    logic [itf_pkg::POS_W-1:0] r_total;
    logic [itf_pkg::POS_W-1:0] bnd_b1;
    logic [itf_pkg::POS_W-1:0] bnd_b2;
    logic [itf_pkg::POS_W-1:0] bnd_b3;
    logic [itf_pkg::POS_W-1:0] bnd_b5;
    logic [itf_pkg::POS_W-1:0] bnd_b6;

    assign bnd_b1 = (!r_left && !r_zpad) ? r_pad : '0;
    assign bnd_b2 = bnd_b1 + itf_pkg::POS_W'(r_sign_len);
    assign bnd_b3 = bnd_b2 + itf_pkg::POS_W'(r_pfx_len);
    assign bnd_b5 = bnd_b3 + (r_zpad ? r_pad : '0) +
                    ({1'b0, r_prec} - itf_pkg::POS_W'(r_cnt));
    assign bnd_b6 = bnd_b5 + itf_pkg::POS_W'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.bound) begin
            r_b1    <= bnd_b1;
            r_b2    <= bnd_b2;
            r_b3    <= bnd_b3;
            r_b5    <= bnd_b5;
            r_b6    <= bnd_b6;
            r_total <= bnd_b6 + (r_left ? r_pad : '0);
        end
    end

    // Character position counter.
    logic [itf_pkg::IDX_W-1:0]     r_idx;
    logic [itf_pkg::POS_W-1:0]     emit_pos;
    logic [itf_pkg::POS_W-1:0]     emit_back;
    logic [itf_pkg::DIG_IDX_W-1:0] emit_dig;
    logic [7:0]                    emit_char;
    logic                          emit_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.bound) begin
            r_idx <= '0;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + itf_pkg::IDX_W'(1);
        end
    end

    // Character selection by run; digits are read most significant first.
    assign emit_pos  = itf_pkg::POS_W'(r_idx);
    assign emit_back = r_b6 - itf_pkg::POS_W'(1) - emit_pos;
    assign emit_dig  = emit_back[itf_pkg::DIG_IDX_W-1:0];
    assign emit_last = (emit_pos + itf_pkg::POS_W'(1) == r_total) ||
                       (emit_pos == itf_pkg::POS_W'(itf_pkg::OUT_LIMIT - 1));

    always_comb begin
        emit_char = itf_pkg::CH_SPACE;
        if (emit_pos < r_b1) begin
            emit_char = itf_pkg::CH_SPACE;
        end else if (emit_pos < r_b2) begin
            emit_char = r_sign_char;
        end else if (emit_pos < r_b3) begin
            if (emit_pos == r_b2) begin
                emit_char = itf_pkg::CH_ZERO;
            end else begin
                emit_char = r_upper ? itf_pkg::CH_X_UP : itf_pkg::CH_X_LO;
            end
        end else if (emit_pos < r_b5) begin
            emit_char = itf_pkg::CH_ZERO;
        end else if (emit_pos < r_b6) begin
            emit_char = itf_pkg::digit_char(r_store[emit_dig], r_upper);
        end
    end

    // Output register; it holds a character while the receiver stalls.
    logic                          r_out_valid;
    logic [itf_pkg::M_TDATA_W-1:0] r_out_char;
    logic                          r_out_last;
    logic                          r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
            r_out_err  <= 1'b0;
        end else if (i_cmd.err) begin
            r_out_char <= itf_pkg::CH_NUL;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;
    assign o_out_err   = r_out_err;

    // Status to the controller.
    assign o_sts.radix_bad = (in_radix < itf_pkg::RADIX_MIN) || (in_radix > itf_pkg::RADIX_MAX);
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.emit_last = emit_last;

endmodule

`default_nettype wire

/* rtl/itf_checker.sv */
// Port checker of the integer to text formatter and its bind to the top level.
`default_nettype none

module itf_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [itf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                          m_axis_tlast,
    input wire logic                          m_axis_tuser
);

    // An error result is a lone NUL character that closes its number.
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == itf_pkg::CH_NUL))
        else $error("error transaction without tlast or with nonzero character");

    // One number at a time: after an input transaction the block is busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an input transaction");

    // No new number is taken while the text of the current one is unfinished.
    a_no_accept_mid_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready while a number is still being emitted");

    // A stalled character holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
            $stable(m_axis_tuser))
        else $error("output transaction changed while stalled");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
